>>> hw/rtl/pom_pkg.sv
package pom_pkg;

    localparam int SAMPLE_BITS = 10;
    localparam int PROD_W      = 2 * SAMPLE_BITS;

    localparam int STEP_W  = 8;
    localparam int DUTY_W  = 10;
    localparam int POWER_W = 20;
    // signed duty arithmetic: duty + step never exceeds this range
    localparam int CALC_W  = DUTY_W + 2;
    // common width for comparing the product against 20-bit values
    localparam int CMP_W   = (PROD_W > POWER_W) ? PROD_W : POWER_W;

    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 4;

    localparam logic [POWER_W-1:0] POWER_MAX = {POWER_W{1'b1}};

    localparam logic [STEP_W-1:0]  STEP_RESET    = STEP_W'(10);
    localparam logic [DUTY_W-1:0]  FLOOR_RESET   = DUTY_W'(51);
    localparam logic [DUTY_W-1:0]  CEILING_RESET = DUTY_W'(973);
    localparam logic [POWER_W-1:0] LIMIT_RESET   = POWER_MAX;

    typedef logic [SAMPLE_BITS-1:0] sample_t;
    typedef logic [PROD_W-1:0]      product_t;
    typedef logic [DUTY_W-1:0]      duty_t;
    typedef logic [STEP_W-1:0]      step_t;
    typedef logic [POWER_W-1:0]     power_t;

    typedef enum logic [1:0] {
        REG_STEP_SIZE    = 2'd0,
        REG_DUTY_FLOOR   = 2'd1,
        REG_DUTY_CEILING = 2'd2,
        REG_POWER_LIMIT  = 2'd3
    } reg_idx_t;

endpackage

>>> hw/rtl/pom_sample_if.sv
interface pom_sample_if;
    logic             valid;
    logic             ready;
    pom_pkg::sample_t voltage_code;
    pom_pkg::sample_t current_code;

    modport source (output valid, output voltage_code, output current_code, input ready);
    modport sink   (input valid, input voltage_code, input current_code, output ready);
endinterface

>>> hw/rtl/pom_result_if.sv
interface pom_result_if;
    logic            valid;
    logic            ready;
    pom_pkg::duty_t  duty_level;
    pom_pkg::power_t panel_power;
    logic            pwm_enabled;

    modport source (output valid, output duty_level, output panel_power,
                    output pwm_enabled, input ready);
    modport sink   (input valid, input duty_level, input panel_power,
                    input pwm_enabled, output ready);
endinterface

>>> hw/rtl/perturb_observe_mppt.sv
// A sample transaction passes the stage 1 register (multiply) and then the
// result register (update) before its result transaction appears.
// Throughput: one sample per cycle unless the result stalls; the tracker
// state update closes in the second stage, so samples issue back to back.
// Reset (rst_n, async, active low): duty, last voltage/power and trip flag
// clear; config registers return to step 10, floor 51, ceiling 973, limit max.
module perturb_observe_mppt (
    input  logic                             clk,
    input  logic                             rst_n,
    pom_sample_if.sink                       sample,
    pom_result_if.source                     result,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [pom_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [pom_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [pom_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready
);

    // ------------------------------------------------------------------
    // Configuration registers (APB, word addressed, zero wait state)
    // ------------------------------------------------------------------
    pom_pkg::step_t    step_size_reg;
    pom_pkg::duty_t    duty_floor_reg;
    pom_pkg::duty_t    duty_ceiling_reg;
    pom_pkg::power_t   power_limit_reg;

    logic              cfg_write;
    pom_pkg::reg_idx_t cfg_idx;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_idx   = pom_pkg::reg_idx_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_size_reg    <= pom_pkg::STEP_RESET;
            duty_floor_reg   <= pom_pkg::FLOOR_RESET;
            duty_ceiling_reg <= pom_pkg::CEILING_RESET;
            power_limit_reg  <= pom_pkg::LIMIT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_idx)
                pom_pkg::REG_STEP_SIZE:
                    step_size_reg <= pwdata[pom_pkg::STEP_W-1:0];
                pom_pkg::REG_DUTY_FLOOR:
                    duty_floor_reg <= pwdata[pom_pkg::DUTY_W-1:0];
                pom_pkg::REG_DUTY_CEILING:
                    duty_ceiling_reg <= pwdata[pom_pkg::DUTY_W-1:0];
                pom_pkg::REG_POWER_LIMIT:
                    power_limit_reg <= pwdata[pom_pkg::POWER_W-1:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            pom_pkg::REG_STEP_SIZE:    prdata = pom_pkg::APB_DATA_W'(step_size_reg);
            pom_pkg::REG_DUTY_FLOOR:   prdata = pom_pkg::APB_DATA_W'(duty_floor_reg);
            pom_pkg::REG_DUTY_CEILING: prdata = pom_pkg::APB_DATA_W'(duty_ceiling_reg);
            pom_pkg::REG_POWER_LIMIT:  prdata = pom_pkg::APB_DATA_W'(power_limit_reg);
        endcase
    end

    // ------------------------------------------------------------------
    // Handshake control: stage 1 holds voltage and product, the result
    // register parts the tracker from the downstream consumer.
    // ------------------------------------------------------------------
    logic s1_valid_reg, s1_valid_next;
    logic out_valid_reg, out_valid_next;
    logic in_fire, s1_fire;

    assign s1_fire      = s1_valid_reg && (!out_valid_reg || result.ready);
    assign sample.ready = !s1_valid_reg || s1_fire;
    assign in_fire      = sample.valid && sample.ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_fire)
            s1_valid_next = 1'b1;
        else if (s1_fire)
            s1_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (s1_fire)
            out_valid_next = 1'b1;
        else if (result.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: panel power = V * I, registered with the voltage
    // ------------------------------------------------------------------
    pom_pkg::sample_t  s1_voltage_reg;
    pom_pkg::product_t s1_power_reg;

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_voltage_reg <= sample.voltage_code;
            s1_power_reg   <= pom_pkg::PROD_W'(sample.voltage_code) *
                              pom_pkg::PROD_W'(sample.current_code);
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: perturb & observe decision, clamp, trip, state update
    // ------------------------------------------------------------------
    pom_pkg::sample_t  last_voltage_reg;
    pom_pkg::product_t last_power_reg;
    pom_pkg::duty_t    duty_now_reg;
    logic              tripped_reg;

    logic                              power_rose;
    logic                              voltage_up;
    logic [pom_pkg::CMP_W-1:0]         power_wide;
    logic signed [pom_pkg::CALC_W-1:0] duty_cur;
    logic signed [pom_pkg::CALC_W-1:0] step_s;
    logic signed [pom_pkg::CALC_W-1:0] duty_moved;
    logic signed [pom_pkg::CALC_W-1:0] duty_capped;
    logic signed [pom_pkg::CALC_W-1:0] duty_clamped;
    logic signed [pom_pkg::CALC_W-1:0] ceil_s;
    logic signed [pom_pkg::CALC_W-1:0] floor_s;
    pom_pkg::duty_t                    duty_next;
    logic                              tripped_next;
    pom_pkg::power_t                   power_sat;

    always_comb
    begin
        power_rose = s1_power_reg > last_power_reg;
        voltage_up = s1_voltage_reg > last_voltage_reg;
        power_wide = pom_pkg::CMP_W'(s1_power_reg);

        duty_cur = signed'(pom_pkg::CALC_W'(duty_now_reg));
        step_s   = signed'(pom_pkg::CALC_W'(step_size_reg));
        ceil_s   = signed'(pom_pkg::CALC_W'(duty_ceiling_reg));
        floor_s  = signed'(pom_pkg::CALC_W'(duty_floor_reg));

        // same direction as the voltage when power rose, else reverse
        if (power_rose == voltage_up)
            duty_moved = duty_cur + step_s;
        else
            duty_moved = duty_cur - step_s;

        // ceiling first, then floor: floor wins if they cross
        duty_capped  = (duty_moved > ceil_s) ? ceil_s : duty_moved;
        duty_clamped = (duty_capped < floor_s) ? floor_s : duty_capped;
        duty_next    = duty_clamped[pom_pkg::DUTY_W-1:0];

        // trip on this sample's power, so it already reports PWM off
        tripped_next = tripped_reg ||
                       (power_wide > pom_pkg::CMP_W'(power_limit_reg));

        if (power_wide > pom_pkg::CMP_W'(pom_pkg::POWER_MAX))
            power_sat = pom_pkg::POWER_MAX;
        else
            power_sat = power_wide[pom_pkg::POWER_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_voltage_reg <= '0;
            last_power_reg   <= '0;
            duty_now_reg     <= '0;
            tripped_reg      <= 1'b0;
        end
        else if (s1_fire)
        begin
            last_voltage_reg <= s1_voltage_reg;
            last_power_reg   <= s1_power_reg;
            duty_now_reg     <= duty_next;
            tripped_reg      <= tripped_next;
        end
    end

    // result register
    pom_pkg::duty_t  out_duty_reg;
    pom_pkg::power_t out_power_reg;
    logic            out_pwm_reg;

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            out_duty_reg  <= duty_next;
            out_power_reg <= power_sat;
            out_pwm_reg   <= !tripped_next;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.duty_level  = out_duty_reg;
    assign result.panel_power = out_power_reg;
    assign result.pwm_enabled = out_pwm_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_trip_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        tripped_reg |=> tripped_reg)
        else $error("overload flag cleared without reset");

    a_pwm_matches_flag: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.pwm_enabled == !tripped_reg))
        else $error("pending result disagrees with trip flag");

    a_duty_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.duty_level == duty_now_reg))
        else $error("pending result disagrees with tracker duty");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !result.ready) |=> $stable(duty_now_reg) && $stable(last_power_reg))
        else $error("tracker state advanced while result stalled");

endmodule
